### design/phi_pkg.sv
`default_nettype none

package phi_pkg;

    localparam int AGENTS_DEF = 4;
    localparam int DEPTH_DEF  = 16;

    localparam int TIME_W = 32;
    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int PROD_W = FRAC_W + 1 + DATA_W + 1;

    localparam logic [TIME_W-1:0] SPAN_RESET = 32'd100000;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [1:0]         agent;
        logic [TIME_W-1:0]  sample_time;
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] heading;
    } phi_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_heading;
        logic               history_empty;
    } phi_res_t;

    typedef struct packed {
        logic [TIME_W-1:0] tstamp;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] hd;
    } phi_entry_t;

    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] rem;
        logic [FRAC_W-1:0] quo;
    } phi_div_link_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REC_CHK,
        ST_REC_WR,
        ST_TRIM_CHK,
        ST_QF_CHK,
        ST_QL_CHK,
        ST_SRCH_CHK,
        ST_DIV,
        ST_MUL,
        ST_ADD
    } phi_state_t;

endpackage

`default_nettype wire

### design/phi_div_cell.sv
`default_nettype none

module phi_div_cell
    import phi_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire phi_div_link_t     link_in,
    input  wire logic [TIME_W-1:0] divisor,
    output phi_div_link_t          link_out
);

    logic [TIME_W:0] dbl;
    logic            ge;
    phi_div_link_t   link_reg;
    phi_div_link_t   link_next;

    // one restoring step: shift in a zero, subtract when it fits
    always_comb
    begin
        dbl             = {link_in.rem, 1'b0};
        ge              = (dbl >= {1'b0, divisor});
        link_next.valid = link_in.valid;
        link_next.rem   = ge ? TIME_W'(dbl - {1'b0, divisor}) : dbl[TIME_W-1:0];
        link_next.quo   = {link_in.quo[FRAC_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

`default_nettype wire

### design/pose_history_interpolator.sv
`default_nettype none

// channel    | handshake              | payload
// request    | start in, busy out     | request (phi_req_t)
// result     | result_valid out       | result (phi_res_t)
// config     | span_we in             | span_wdata (trim span)
//
// a record checks the newest entry if there is one, writes, then trims stale entries one at a time
// a query answers straight from idle when empty, after the first or last entry check
// when clamped, otherwise after a search over the entries, then the divider chain
// and the shared multiplier, which serves the x, y and heading lanes in turn
// reset clears counts and ring pointers, entries stay undefined until written
// results are strobed for one cycle; the receiver cannot stall them

module pose_history_interpolator
    import phi_pkg::*;
#(
    parameter int AGENTS = AGENTS_DEF,
    parameter int DEPTH  = DEPTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire phi_req_t          request,
    output logic                   result_valid,
    output phi_res_t               result,
    input  wire logic              span_we,
    input  wire logic [TIME_W-1:0] span_wdata
);

    localparam int SW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int AGW  = (AGENTS > 1) ? $clog2(AGENTS) : 1;
    localparam int AW   = $clog2(AGENTS * DEPTH);
    localparam int SUMW = CW + 1;

    function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] base,
                                               input logic [CW-1:0] k);
        logic [SUMW-1:0] sum;
        sum = SUMW'(base) + SUMW'(k);
        if (sum >= SUMW'(DEPTH))
        begin
            sum = sum - SUMW'(DEPTH);
        end
        return sum[SW-1:0];
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [AGW-1:0] ag,
                                              input logic [SW-1:0] slot);
        return AW'(int'(ag) * DEPTH + int'(slot));
    endfunction

    phi_entry_t mem [AGENTS*DEPTH];
    phi_entry_t rd_reg;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;
    logic [SW-1:0]   rd_slot;
    logic [SW-1:0]   wr_slot;

    phi_state_t      state_reg, state_next;
    phi_req_t        item_reg, item_next;
    logic [AGW-1:0]  agi_reg, agi_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [SW-1:0]   old_reg, old_next;
    logic [CW-1:0]   k_reg, k_next;
    phi_entry_t      a_reg, a_next;
    phi_entry_t      b_reg, b_next;
    logic [FRAC_W-1:0] u_reg, u_next;
    logic [1:0]      lane_reg, lane_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    phi_res_t        res_reg, res_next;
    logic            valid_reg, valid_next;
    logic [TIME_W-1:0] span_reg;
    logic [CW-1:0]   count_reg [AGENTS];
    logic [SW-1:0]   oldest_reg [AGENTS];
    logic            commit;

    logic              div_go_reg, div_go_next;
    logic [TIME_W-1:0] div_r0_reg, div_r0_next;
    logic [TIME_W-1:0] div_d_reg, div_d_next;
    phi_div_link_t     link [FRAC_W+1];

    assign link[0] = '{valid: div_go_reg, rem: div_r0_reg, quo: '0};

    for (genvar i = 0; i < FRAC_W; i++)
    begin : g_div
        phi_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .link_in  (link[i]),
            .divisor  (div_d_reg),
            .link_out (link[i+1])
        );
    end

    always_comb
    begin
        logic             ag_ok;
        logic [AGW-1:0]   agi_in;
        logic             full;
        logic [SW-1:0]    eff_old;
        logic [CW-1:0]    eff_cnt;
        logic [DATA_W:0]  diff_sel;
        logic [DATA_W-1:0] a_sel;
        logic [DATA_W-1:0] hdiff;
        logic [PROD_W-1:0] rounded;
        logic [DATA_W-1:0] sum_out;

        state_next  = state_reg;
        item_next   = item_reg;
        agi_next    = agi_reg;
        cnt_next    = cnt_reg;
        old_next    = old_reg;
        k_next      = k_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        u_next      = u_reg;
        lane_next   = lane_reg;
        prod_next   = prod_reg;
        res_next    = res_reg;
        valid_next  = 1'b0;
        div_go_next = 1'b0;
        div_r0_next = div_r0_reg;
        div_d_next  = div_d_reg;
        wr_en       = 1'b0;
        commit      = 1'b0;
        rd_slot     = '0;

        ag_ok   = ({30'b0, request.agent} < 32'(AGENTS));
        agi_in  = ag_ok ? AGW'(request.agent) : '0;
        full    = (cnt_reg == CW'(DEPTH));
        eff_old = full ? slot_add(old_reg, CW'(1)) : old_reg;
        eff_cnt = full ? cnt_reg - CW'(1) : cnt_reg;
        wr_slot = slot_add(eff_old, eff_cnt);

        hdiff = b_reg.hd - a_reg.hd;
        case (lane_reg)
            2'd0:
            begin
                diff_sel = {b_reg.x[DATA_W-1], b_reg.x} - {a_reg.x[DATA_W-1], a_reg.x};
                a_sel    = a_reg.x;
            end
            2'd1:
            begin
                diff_sel = {b_reg.y[DATA_W-1], b_reg.y} - {a_reg.y[DATA_W-1], a_reg.y};
                a_sel    = a_reg.y;
            end
            default:
            begin
                // shortest arc: wrapped difference, half a turn reads negative
                diff_sel = {hdiff[DATA_W-1], hdiff};
                a_sel    = a_reg.hd;
            end
        endcase
        rounded = PROD_W'((prod_reg + PROD_W'(32768)) >>> FRAC_W);
        sum_out = a_sel + rounded[DATA_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next = request;
                    agi_next  = agi_in;
                    cnt_next  = count_reg[agi_in];
                    old_next  = oldest_reg[agi_in];
                    if (request.kind == KIND_RECORD)
                    begin
                        if (ag_ok && count_reg[agi_in] != '0)
                        begin
                            rd_slot    = slot_add(oldest_reg[agi_in],
                                                  count_reg[agi_in] - CW'(1));
                            state_next = ST_REC_CHK;
                        end
                        else if (ag_ok)
                        begin
                            state_next = ST_REC_WR;
                        end
                    end
                    else if (!ag_ok || count_reg[agi_in] == '0)
                    begin
                        res_next   = '{out_x: '0, out_y: '0, out_heading: '0,
                                       history_empty: 1'b1};
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        rd_slot    = oldest_reg[agi_in];
                        state_next = ST_QF_CHK;
                    end
                end
            end
            ST_REC_CHK:
            begin
                state_next = (item_reg.sample_time <= rd_reg.tstamp) ? ST_IDLE : ST_REC_WR;
            end
            ST_REC_WR:
            begin
                wr_en    = 1'b1;
                old_next = eff_old;
                cnt_next = eff_cnt + CW'(1);
                if (eff_cnt + CW'(1) > CW'(2))
                begin
                    rd_slot    = slot_add(eff_old, CW'(1));
                    state_next = ST_TRIM_CHK;
                end
                else
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_TRIM_CHK:
            begin
                // cutoff sum is kept 33 bits wide so it never wraps
                if ({1'b0, rd_reg.tstamp} + {1'b0, span_reg}
                    <= {1'b0, item_reg.sample_time})
                begin
                    old_next = slot_add(old_reg, CW'(1));
                    cnt_next = cnt_reg - CW'(1);
                    if (cnt_reg - CW'(1) > CW'(2))
                    begin
                        rd_slot = slot_add(slot_add(old_reg, CW'(1)), CW'(1));
                    end
                    else
                    begin
                        commit     = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_QF_CHK:
            begin
                if (item_reg.sample_time <= rd_reg.tstamp)
                begin
                    res_next   = '{out_x: rd_reg.x, out_y: rd_reg.y,
                                   out_heading: rd_reg.hd, history_empty: 1'b0};
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    a_next     = rd_reg;
                    rd_slot    = slot_add(old_reg, cnt_reg - CW'(1));
                    state_next = ST_QL_CHK;
                end
            end
            ST_QL_CHK:
            begin
                if (item_reg.sample_time >= rd_reg.tstamp)
                begin
                    res_next   = '{out_x: rd_reg.x, out_y: rd_reg.y,
                                   out_heading: rd_reg.hd, history_empty: 1'b0};
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next     = CW'(1);
                    rd_slot    = slot_add(old_reg, CW'(1));
                    state_next = ST_SRCH_CHK;
                end
            end
            ST_SRCH_CHK:
            begin
                if (k_reg < cnt_reg - CW'(1) && rd_reg.tstamp < item_reg.sample_time)
                begin
                    a_next  = rd_reg;
                    k_next  = k_reg + CW'(1);
                    rd_slot = slot_add(old_reg, k_reg + CW'(1));
                end
                else if (rd_reg.tstamp == item_reg.sample_time)
                begin
                    res_next   = '{out_x: rd_reg.x, out_y: rd_reg.y,
                                   out_heading: rd_reg.hd, history_empty: 1'b0};
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    b_next      = rd_reg;
                    div_go_next = 1'b1;
                    div_r0_next = item_reg.sample_time - a_reg.tstamp;
                    div_d_next  = rd_reg.tstamp - a_reg.tstamp;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (link[FRAC_W].valid)
                begin
                    u_next     = link[FRAC_W].quo;
                    lane_next  = 2'd0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = $signed({1'b0, u_reg}) * $signed(diff_sel);
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                case (lane_reg)
                    2'd0:    res_next.out_x = sum_out;
                    2'd1:    res_next.out_y = sum_out;
                    default: res_next.out_heading = sum_out;
                endcase
                if (lane_reg == 2'd2)
                begin
                    res_next.history_empty = 1'b0;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    lane_next  = lane_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_addr = addr_of(state_reg == ST_IDLE ? agi_next : agi_reg, rd_slot);
    assign wr_addr = addr_of(agi_reg, wr_slot);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= '{tstamp: item_reg.sample_time, x: item_reg.pos_x,
                              y: item_reg.pos_y, hd: item_reg.heading};
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            valid_reg  <= 1'b0;
            div_go_reg <= 1'b0;
            span_reg   <= SPAN_RESET;
            for (int i = 0; i < AGENTS; i++)
            begin
                count_reg[i]  <= '0;
                oldest_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            div_go_reg <= div_go_next;
            if (span_we)
            begin
                span_reg <= span_wdata;
            end
            if (commit)
            begin
                count_reg[agi_reg]  <= cnt_next;
                oldest_reg[agi_reg] <= old_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        agi_reg    <= agi_next;
        cnt_reg    <= cnt_next;
        old_reg    <= old_next;
        k_reg      <= k_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        u_reg      <= u_next;
        lane_reg   <= lane_next;
        prod_reg   <= prod_next;
        res_reg    <= res_next;
        div_r0_reg <= div_r0_next;
        div_d_reg  <= div_d_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

### design/phi_checker.sv
`default_nettype none

module phi_checker
    import phi_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire logic     result_valid,
    input wire phi_res_t result
);

    // an empty history answers with a zero pose
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.history_empty |->
            result.out_x == '0 && result.out_y == '0 && result.out_heading == '0)
        else $error("empty answer carries a nonzero pose");

    // a result ends the request, so the block is free again
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result while still busy");

    // busy only rises after a request was taken
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without a request");

    // a result follows either an accepted request or ongoing work
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start) || $past(busy))
        else $error("result with no request behind it");

endmodule

bind pose_history_interpolator phi_checker u_phi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

`default_nettype wire

### dv/tb_top.sv
module tb_top;
    import phi_pkg::*;

    localparam int NAG = 4;
    localparam int NDEP = 16;
    localparam int RAND_ITEMS = 1500;
    localparam int WATCHDOG = 20000;
    localparam int SETTLE = 80;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    phi_req_t request;
    logic result_valid;
    phi_res_t result;
    logic span_we;
    logic [TIME_W-1:0] span_wdata;

    pose_history_interpolator uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .result_valid(result_valid), .result(result),
        .span_we(span_we), .span_wdata(span_wdata)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow pose history
    logic [31:0] span_m;
    logic [31:0] h_time [NAG][NDEP];
    logic [31:0] h_x [NAG][NDEP];
    logic [31:0] h_y [NAG][NDEP];
    logic [31:0] h_hd [NAG][NDEP];
    int unsigned h_cnt [NAG];
    int unsigned h_old [NAG];
    logic [31:0] last_t [NAG];

    phi_res_t pose_q [$];
    int fails = 0;
    int idle_cycles = 0;

    function automatic int unsigned slot(int unsigned ag, int unsigned k);
        return (h_old[ag] + k) % NDEP;
    endfunction

    function automatic logic signed [63:0] lerp_delta(logic [15:0] u,
                                                     logic signed [63:0] d);
        logic signed [63:0] p;
        p = $signed({48'd0, u}) * d + 64'sd32768;
        return p >>> 16;
    endfunction

    function automatic phi_res_t entry_res(int unsigned ag, int unsigned s);
        phi_res_t r;
        r.out_x = h_x[ag][s];
        r.out_y = h_y[ag][s];
        r.out_heading = h_hd[ag][s];
        r.history_empty = 1'b0;
        return r;
    endfunction

    task automatic predict_pose(input phi_req_t rq);
        int unsigned ag;
        int unsigned n;
        int unsigned k;
        int unsigned sa;
        int unsigned sb;
        logic [31:0] t;
        logic [63:0] num;
        logic [63:0] uu;
        logic [15:0] u;
        logic [31:0] hdiff;
        phi_res_t r;
        ag = rq.agent;
        t = rq.sample_time;
        n = h_cnt[ag];
        if (rq.kind == KIND_RECORD)
        begin
            if (n > 0 && t <= h_time[ag][slot(ag, n - 1)])
                return;
            if (n >= NDEP)
            begin
                h_old[ag] = (h_old[ag] + 1) % NDEP;
                h_cnt[ag]--;
            end
            sa = slot(ag, h_cnt[ag]);
            h_time[ag][sa] = t;
            h_x[ag][sa] = rq.pos_x;
            h_y[ag][sa] = rq.pos_y;
            h_hd[ag][sa] = rq.heading;
            h_cnt[ag]++;
            last_t[ag] = t;
            while (h_cnt[ag] > 2 &&
                   {32'd0, h_time[ag][slot(ag, 1)]} + {32'd0, span_m} <= {32'd0, t})
            begin
                h_old[ag] = (h_old[ag] + 1) % NDEP;
                h_cnt[ag]--;
            end
            return;
        end
        if (n == 0)
        begin
            r = '0;
            r.history_empty = 1'b1;
            pose_q = {pose_q, r};
            return;
        end
        if (t <= h_time[ag][slot(ag, 0)])
        begin
            pose_q = {pose_q, entry_res(ag, slot(ag, 0))};
            return;
        end
        if (t >= h_time[ag][slot(ag, n - 1)])
        begin
            pose_q = {pose_q, entry_res(ag, slot(ag, n - 1))};
            return;
        end
        k = 1;
        while (k < n - 1 && h_time[ag][slot(ag, k)] < t)
            k++;
        sb = slot(ag, k);
        sa = slot(ag, k - 1);
        if (h_time[ag][sb] == t)
        begin
            pose_q = {pose_q, entry_res(ag, sb)};
            return;
        end
        num = {32'd0, t - h_time[ag][sa]} << 16;
        uu = num / {32'd0, h_time[ag][sb] - h_time[ag][sa]};
        u = (uu > 64'd65535) ? 16'hffff : uu[15:0];
        r.out_x = 32'($signed(h_x[ag][sa]) + lerp_delta(u,
                  64'($signed(h_x[ag][sb])) - 64'($signed(h_x[ag][sa]))));
        r.out_y = 32'($signed(h_y[ag][sa]) + lerp_delta(u,
                  64'($signed(h_y[ag][sb])) - 64'($signed(h_y[ag][sa]))));
        hdiff = h_hd[ag][sb] - h_hd[ag][sa];
        r.out_heading = h_hd[ag][sa] + 32'(lerp_delta(u, 64'($signed(hdiff))));
        r.history_empty = 1'b0;
        pose_q = {pose_q, r};
    endtask

    // result checker and watchdog
    always @(posedge clk)
    begin
        phi_res_t e;
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (result_valid)
            begin
                if (pose_q.size() == 0)
                begin
                    $error("unexpected result");
                    fails++;
                end
                else
                begin
                    e = pose_q.pop_front();
                    if (result.out_x !== e.out_x)
                    begin
                        $error("out_x exp %h got %h", e.out_x, result.out_x);
                        fails++;
                    end
                    if (result.out_y !== e.out_y)
                    begin
                        $error("out_y exp %h got %h", e.out_y, result.out_y);
                        fails++;
                    end
                    if (result.out_heading !== e.out_heading)
                    begin
                        $error("out_heading exp %h got %h", e.out_heading,
                               result.out_heading);
                        fails++;
                    end
                    if (result.history_empty !== e.history_empty)
                    begin
                        $error("history_empty exp %b got %b", e.history_empty,
                               result.history_empty);
                        fails++;
                    end
                end
            end
            if (idle_cycles > WATCHDOG)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_request(input phi_req_t rq);
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 120) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0)
            g = 0;
        repeat (g) @(posedge clk);
        // look at busy away from the rising edge
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        request <= rq;
        start <= 1'b1;
        @(posedge clk);
        start <= 1'b0;
        predict_pose(rq);
    endtask

    task automatic drain();
        while (pose_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_span(input logic [31:0] v);
        drain();
        span_we <= 1'b1;
        span_wdata <= v;
        @(posedge clk);
        span_we <= 1'b0;
        span_m = v;
    endtask

    function automatic phi_req_t mk(logic k, logic [1:0] ag, logic [31:0] t,
                                   logic [31:0] x, logic [31:0] y, logic [31:0] h);
        phi_req_t r;
        r.kind = k;
        r.agent = ag;
        r.sample_time = t;
        r.pos_x = x;
        r.pos_y = y;
        r.heading = h;
        return r;
    endfunction

    // directed rows; fixed flag means typed expected result
    typedef struct {
        phi_req_t rq;
        bit fixed;
        phi_res_t res;
    } row_t;

    row_t rows [$];

    task automatic add_row(phi_req_t rq, bit fixed, phi_res_t r);
        row_t w;
        w.rq = rq;
        w.fixed = fixed;
        w.res = r;
        rows = {rows, w};
    endtask

    initial
    begin
        phi_req_t rq;
        phi_res_t z;
        phi_res_t ex;
        int kind_sel;
        int ag;
        logic [31:0] tt;
        start = 1'b0;
        request = '0;
        span_we = 1'b0;
        span_wdata = '0;
        rst_n = 1'b0;
        span_m = SPAN_RESET;
        for (int a = 0; a < NAG; a++)
        begin
            h_cnt[a] = 0;
            h_old[a] = 0;
            last_t[a] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        z = '0;
        z.history_empty = 1'b1;
        ex = '0;
        add_row(mk(KIND_QUERY, 0, 32'd0, '1, '1, '1), 1, z);
        add_row(mk(KIND_QUERY, 3, 32'hffffffff, 0, 0, 0), 1, z);
        add_row(mk(KIND_RECORD, 0, 32'd0, 32'h7fffffff, 32'h80000000, 32'h7fffffff), 0, ex);
        ex.out_x = 32'h7fffffff; ex.out_y = 32'h80000000; ex.out_heading = 32'h7fffffff;
        add_row(mk(KIND_QUERY, 0, 32'hffffffff, 0, 0, 0), 1, ex);
        add_row(mk(KIND_RECORD, 0, 32'd0, 1, 1, 1), 0, ex);       // equal time, skipped
        add_row(mk(KIND_RECORD, 0, 32'd1000, 32'h80000000, 32'h7fffffff, 32'h80000000), 0, ex);
        add_row(mk(KIND_RECORD, 0, 32'd500, 5, 5, 5), 0, ex);     // older, skipped
        add_row(mk(KIND_QUERY, 0, 32'd333, 0, 0, 0), 0, ex);
        add_row(mk(KIND_QUERY, 0, 32'd500, 0, 0, 0), 0, ex);
        add_row(mk(KIND_RECORD, 0, 32'd3000, 32'h10000, 32'h0, 32'h0), 0, ex);
        add_row(mk(KIND_QUERY, 0, 32'd1000, 0, 0, 0), 0, ex);     // on an inner entry
        add_row(mk(KIND_QUERY, 0, 32'd2999, 0, 0, 0), 0, ex);
        add_row(mk(KIND_RECORD, 1, 32'd10, 0, 0, 32'h40000000), 0, ex);
        add_row(mk(KIND_RECORD, 1, 32'd20, 0, 0, 32'hc0000000), 0, ex); // half turn
        add_row(mk(KIND_QUERY, 1, 32'd15, 0, 0, 0), 0, ex);
        add_row(mk(KIND_QUERY, 1, 32'd11, 0, 0, 0), 0, ex);
        add_row(mk(KIND_RECORD, 1, 32'hffffffff, 32'hffff, 32'h1, 32'h3), 0, ex);
        add_row(mk(KIND_QUERY, 1, 32'hfffffffe, 0, 0, 0), 0, ex);
        add_row(mk(KIND_QUERY, 1, 32'd0, 0, 0, 0), 0, ex);
        for (int i = 0; i < rows.size(); i++)
        begin
            if (rows[i].fixed)
            begin
                send_request(rows[i].rq);
                void'(pose_q.pop_back());
                pose_q = {pose_q, rows[i].res};
            end
            else
                send_request(rows[i].rq);
        end

        // full ring, no trimming
        write_span(32'hffffffff);
        for (int i = 0; i < 20; i++)
            send_request(mk(KIND_RECORD, 2, 32'd100 * (i + 1), $urandom, $urandom, $urandom));
        send_request(mk(KIND_QUERY, 2, 32'd1550, 0, 0, 0));
        // span zero trims hard
        write_span(32'd0);
        send_request(mk(KIND_RECORD, 2, 32'd5000, 1, 2, 3));
        send_request(mk(KIND_QUERY, 2, 32'd4000, 0, 0, 0));

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i % 300 == 0)
            begin
                case ((i / 300) % 4)
                    0: write_span($urandom_range(200, 4000));
                    1: write_span(32'hffffffff);
                    2: write_span($urandom);
                    default: write_span($urandom_range(0, 50));
                endcase
            end
            if (i == 750)
                drain();
            ag = $urandom_range(0, 3);
            kind_sel = $urandom_range(0, 99);
            rq.pos_x = $urandom;
            rq.pos_y = $urandom;
            rq.heading = $urandom;
            rq.agent = ag;
            if (kind_sel < 50)
            begin
                rq.kind = KIND_RECORD;
                if (kind_sel < 45)
                begin
                    tt = last_t[ag] + $urandom_range(1, 500);
                    if (tt <= last_t[ag])
                        tt = $urandom;
                end
                else
                    tt = (kind_sel < 47) ? $urandom : last_t[ag] - $urandom_range(0, 3);
                if ($urandom_range(0, 200) == 0)
                    tt = 32'hffffffff;
                rq.sample_time = tt;
            end
            else
            begin
                rq.kind = KIND_QUERY;
                if (kind_sel < 90)
                    rq.sample_time = last_t[ag] - $urandom_range(0, 4000);
                else
                    rq.sample_time = $urandom;
            end
            // occasionally jump time to a random value once it nears the wrap
            if (last_t[ag] > 32'hf0000000 && rq.kind == KIND_RECORD && kind_sel < 3)
                rq.sample_time = $urandom;
            send_request(rq);
        end

        drain();
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

### filelist.f
design/phi_pkg.sv
design/phi_div_cell.sv
design/pose_history_interpolator.sv
design/phi_checker.sv
dv/tb_top.sv
